>>> rtl/core/lcc_pkg.sv
package lcc_pkg;

  // Tag of one stored chunk
  typedef struct packed {
    logic [15:0] chunk_number;
    logic [15:0] clip_id;
  } tag_t;

  // Entry displaced by the walk, carried to the next cell
  typedef struct packed {
    logic valid;
    tag_t tag;
  } entry_t;

  // Lookup token moving down the chain
  typedef struct packed {
    logic act;    // token present at this cell
    logic found;  // lookup already resolved further up
    logic hit;    // resolved as a hit
  } token_t;

  localparam int InWidth  = 32;
  localparam int OutWidth = 8;

endpackage

>>> rtl/core/lcc_cell.sv
module lcc_cell #(
  parameter int SLOT_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lcc_pkg::tag_t        req_tag,
  input  logic                 tail,
  input  logic [SLOT_W-1:0]    init_slot,
  input  logic                 head_load,
  input  logic [SLOT_W-1:0]    head_slot,
  input  lcc_pkg::token_t      in_tok,
  input  lcc_pkg::entry_t      in_carry,
  input  logic [SLOT_W-1:0]    in_carry_slot,
  input  logic [SLOT_W-1:0]    in_res_slot,
  output lcc_pkg::token_t      out_tok,
  output lcc_pkg::entry_t      out_carry,
  output logic [SLOT_W-1:0]    out_carry_slot,
  output logic [SLOT_W-1:0]    out_res_slot
);
  import lcc_pkg::*;

  // Stored entry at this recency position
  logic              valid;
  tag_t              tag;
  logic [SLOT_W-1:0] slot;

  logic              match;
  logic              step;
  logic              resolve;
  token_t            out_tok_next;
  logic [SLOT_W-1:0] out_res_slot_next;

  assign match   = valid && (tag == req_tag);
  assign step    = in_tok.act && !in_tok.found;
  assign resolve = step && (match || tail);

  // Token and result slot handed to the next cell
  always_comb begin
    out_tok_next      = in_tok;
    out_res_slot_next = in_res_slot;
    if (resolve && !head_load) begin
      out_tok_next.found = 1'b1;
      out_tok_next.hit   = match;
      out_res_slot_next  = slot;
    end
  end

  // Control: valid bit, slot number, token
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      slot    <= init_slot;
      out_tok <= '0;
    end else begin
      out_tok <= out_tok_next;
      if (head_load) begin
        valid <= 1'b1;
        slot  <= head_slot;
      end else if (step) begin
        // take the entry pushed down from above
        valid <= in_carry.valid;
        slot  <= in_carry_slot;
      end
    end
  end

  // Payload: tag, carried entry, result slot
  always_ff @(posedge clk) begin
    out_carry      <= '{valid: valid, tag: tag};
    out_carry_slot <= slot;
    out_res_slot   <= out_res_slot_next;
    if (head_load) begin
      tag <= req_tag;
    end else if (step) begin
      tag <= in_carry.tag;
    end
  end

endmodule

>>> rtl/core/lru_chunk_cache_lookup.sv
// Fully associative LRU tag store for (clip, chunk) requests. The store is a
// chain of SLOT_COUNT cells ordered from most to least recently used. A
// request walks the chain one cell per cycle, pushing each entry down one
// place until it meets the matching tag (hit) or reaches the tail (miss,
// tail slot is evicted); the chosen slot is then written at the head with
// the new tag. No new word is accepted until the current lookup's result
// leaves the cell chain, and none while the skid stage is full. Results pass
// through an output register plus one skid stage, so a new word is accepted
// while a result waits in the output register. All slots are empty after
// reset; empty slots never hit and are filled before any valid slot is
// evicted. The slot field carries the low four bits of the slot number.
module lru_chunk_cache_lookup #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lcc_pkg::InWidth-1:0] s_tdata,   // clip_id[15:0], chunk_number[31:16]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lcc_pkg::OutWidth-1:0] m_tdata   // hit[0], slot[4:1], zero[7:5]
);
  import lcc_pkg::*;

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Chain links
  token_t             tok       [0:SLOT_COUNT];
  entry_t             carry     [0:SLOT_COUNT];
  logic [SlotW-1:0]   carry_slot[0:SLOT_COUNT];
  logic [SlotW-1:0]   res_slot  [0:SLOT_COUNT];

  tag_t             req_tag;
  logic             busy;
  logic             start;
  logic             done;
  logic             out_free;
  logic             skid_full;
  logic [4:0]       skid_word;
  logic [SlotW+3:0] res_ext;
  logic [4:0]       res_word;
  logic             accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !rst && !busy && !skid_full;
  assign done     = tok[SLOT_COUNT].act;
  assign out_free = !m_tvalid || m_tready;

  // Result word: hit in bit 0, low four slot bits above it
  assign res_ext  = {4'b0000, res_slot[SLOT_COUNT]};
  assign res_word = {res_ext[3:0], tok[SLOT_COUNT].hit};

  // Head of the chain
  assign tok[0]        = '{act: start, found: 1'b0, hit: 1'b0};
  assign carry[0]      = '0;
  assign carry_slot[0] = '0;
  assign res_slot[0]   = '0;

  // Request register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_tag <= '{chunk_number: s_tdata[31:16], clip_id: s_tdata[15:0]};
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (done && !out_free) begin
        skid_full <= 1'b1;
      end else if (skid_full && m_tready) begin
        skid_full <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= done || skid_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && !out_free) begin
      skid_word <= res_word;
    end
    if (out_free) begin
      if (skid_full) begin
        m_tdata <= {3'b000, skid_word};
      end else begin
        m_tdata <= {3'b000, res_word};
      end
    end
  end

  // Cell chain, position 0 is most recently used
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    lcc_cell #(
      .SLOT_W(SlotW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .req_tag       (req_tag),
      .tail          (i == SLOT_COUNT - 1),
      .init_slot     (SlotW'(i)),
      .head_load     ((i == 0) && done),
      .head_slot     (res_slot[SLOT_COUNT]),
      .in_tok        (tok[i]),
      .in_carry      (carry[i]),
      .in_carry_slot (carry_slot[i]),
      .in_res_slot   (res_slot[i]),
      .out_tok       (tok[i+1]),
      .out_carry     (carry[i+1]),
      .out_carry_slot(carry_slot[i+1]),
      .out_res_slot  (res_slot[i+1])
    );
  end

`ifndef SYNTHESIS
  // A result leaves the chain only for a lookup in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("chain result without a pending lookup");

  // Every lookup leaving the chain is resolved
  a_done_found: assert property (@(posedge clk) disable iff (rst)
    done |-> tok[SLOT_COUNT].found)
    else $error("lookup left the chain unresolved");

  // The skid stage only fills behind a waiting output word
  a_skid_order: assert property (@(posedge clk) disable iff (rst) skid_full |-> m_tvalid)
    else $error("skid stage full while output empty");

  // An accepted word launches a token into the chain
  a_launch: assert property (@(posedge clk) disable iff (rst) accept |=> start && busy)
    else $error("accepted word did not start a walk");
`endif

endmodule

>>> tb/tb_lru_chunk_cache_lookup.sv
module tb_lru_chunk_cache_lookup;

  localparam int SLOTS   = 16;
  localparam int HOT_CNT = 20;
  localparam int RAND_N  = 600;

  // Expected outcome of one lookup
  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } lookup_result_t;

  // LRU tag store predictor plus queue of expected lookup results
  class chunk_lru_scoreboard;
    localparam int N = SLOTS;
    logic [15:0]    tag_clip[N];
    logic [15:0]    tag_chunk[N];
    logic           tag_valid[N];
    int             lru_order[N];  // position 0 = most recent
    lookup_result_t expected_lookups[$];
    int             failures;

    function new();
      for (int i = 0; i < N; i++) begin
        tag_clip[i]  = '0;
        tag_chunk[i] = '0;
        tag_valid[i] = 1'b0;
        lru_order[i] = i;
      end
      failures = 0;
    endfunction

    function lookup_result_t predict_lookup(logic [15:0] clip, logic [15:0] chunk);
      lookup_result_t r;
      int             found;
      int             s;
      found = N;
      for (int pos = 0; pos < N && found == N; pos++) begin
        s = lru_order[pos];
        if (tag_valid[s] && tag_clip[s] == clip && tag_chunk[s] == chunk) found = pos;
      end
      r.hit = (found != N);
      // miss: evict whatever sits at the tail (empty slots stay there)
      if (found == N) begin
        found = N - 1;
        s = lru_order[found];
        tag_clip[s]  = clip;
        tag_chunk[s] = chunk;
        tag_valid[s] = 1'b1;
      end
      s = lru_order[found];
      for (int k = found; k > 0; k--) lru_order[k] = lru_order[k-1];
      lru_order[0] = s;
      r.slot = s[3:0];
      return r;
    endfunction

    function void note_request(logic [31:0] word);
      expected_lookups.push_back(predict_lookup(word[15:0], word[31:16]));
    endfunction

    function void check_result(logic [7:0] word);
      lookup_result_t want;
      if (expected_lookups.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result word %h", word);
        return;
      end
      want = expected_lookups.pop_front();
      if (word[0] !== want.hit || word[4:1] !== want.slot) begin
        failures++;
        if (failures <= 10)
          $display("lookup mismatch: expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                   want.hit, want.slot, word[0], word[4:1]);
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [lcc_pkg::InWidth-1:0] s_tdata  = '0;  // clip_id[15:0], chunk_number[31:16]
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [lcc_pkg::OutWidth-1:0] m_tdata;       // hit[0], slot[4:1], zero[7:5]

  bit                          calm = 1'b0;    // no idling on either side while set
  logic [31:0]                 hot_tags[HOT_CNT];

  chunk_lru_scoreboard lookups;

  lru_chunk_cache_lookup #(
    .SLOT_COUNT(SLOTS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #2 clk = ~clk;

  // Result side: check accepted words, random backpressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) lookups.check_result(m_tdata);
    m_tready <= calm || ($urandom_range(99) >= 27);
  end

  // Present one request word and hold it until accepted
  task automatic send_request(input logic [15:0] clip, input logic [15:0] chunk);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {chunk, clip};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lookups.note_request({chunk, clip});
  endtask

  task automatic drain_lookups();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lookups.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] tag;
    int          pick;
    int          bit_pos;

    lookups = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero tag right after reset must miss, then hit
    send_request(16'h0000, 16'h0000);
    send_request(16'h0000, 16'h0000);
    // Field extremes and alternating bit patterns
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'h0000, 16'hFFFF);
    send_request(16'hAAAA, 16'h5555);
    send_request(16'h5555, 16'hAAAA);
    // Fill the remaining empty slots
    for (int i = 1; i <= 10; i++) send_request(16'(i), 16'(i * 3));
    // Hit on the second-oldest entry, then the deepest hit (oldest entry), then another hit
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h0000, 16'h0000);
    send_request(16'h0001, 16'h0003);
    // Full store: misses now evict the least recent
    send_request(16'h1234, 16'h4321);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'hFFFF, 16'h0001);
    send_request(16'h1234, 16'h4321);

    // Let the pipeline empty before the random part
    drain_lookups();

    for (int i = 0; i < HOT_CNT; i++) hot_tags[i] = $urandom();

    for (int n = 0; n < RAND_N; n++) begin
      calm = (n >= 250 && n < 400);
      if (n == 450) drain_lookups();
      // refresh part of the working set now and then
      if (n % 100 == 99) begin
        for (int k = 0; k < 5; k++) hot_tags[$urandom_range(HOT_CNT-1)] = $urandom();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        tag = hot_tags[$urandom_range(HOT_CNT-1)];
      end else if (pick < 85) begin
        tag = $urandom();
      end else begin
        // near miss: working-set tag with one bit flipped
        tag = hot_tags[$urandom_range(HOT_CNT-1)];
        bit_pos = $urandom_range(31);
        tag[bit_pos] = ~tag[bit_pos];
      end
      send_request(tag[15:0], tag[31:16]);
    end
    calm = 1'b0;

    drain_lookups();
    repeat (SLOTS + 4) @(posedge clk);
    if (lookups.failures == 0 && lookups.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> lru_chunk_cache_lookup.f
rtl/core/lcc_pkg.sv
rtl/core/lcc_cell.sv
rtl/core/lru_chunk_cache_lookup.sv
tb/tb_lru_chunk_cache_lookup.sv
